@@ design/pbs_pkg.sv @@
// Shared constants and widths for the population branch statistic pipeline.
`timescale 1ns / 1ps
package pbs_pkg;

  localparam int P_W       = 17;                // frequency, Q0.16 with room for 1.0
  localparam int N_W       = 16;                // allele count
  localparam int Q_W       = 31;                // p(1-p)/(n-1) term
  localparam int DIV_STEPS = Q_W;               // one quotient bit per stage
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int X_W       = 33;                // log argument
  localparam int E_W       = 6;                 // log exponent
  localparam int LOG_FB    = 30;                // log fraction bits
  localparam int M_W       = LOG_FB + 1;        // Q1.30 mantissa
  localparam int L_W       = E_W + LOG_FB;
  localparam int LOG_LAT   = LOG_FB + 2;
  localparam int NUM_W     = 35;                // signed Fst numerator
  localparam int SPLIT     = 18;                // partial product split of the log difference
  localparam int LN2_W     = 28;
  localparam int PP_W      = SPLIT + LN2_W;
  localparam int LANE_LAT  = DIV_LAT + LOG_LAT + 5;
  localparam int MERGE_LAT = 2;
  localparam int OUT_W     = 20;

  localparam logic [P_W-1:0]   FREQ_ONE = 17'h10000;
  localparam logic [LN2_W-1:0] LN2_Q28  = 28'd186065279;
  localparam logic [OUT_W-1:0] OUT_MAX  = 20'hFFFFF;

endpackage

@@ design/pbs_div.sv @@
// Pipelined divider forming p(1-p)/(n-1) for one population.
`timescale 1ns / 1ps
module pbs_div import pbs_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [P_W-1:0] freq,
  input  logic [N_W-1:0] count,
  output logic [Q_W-1:0] term
);

  logic [P_W-1:0]   cmp;
  logic [2*P_W-1:0] prod;
  logic [Q_W-1:0]   x_r, x_nxt;
  logic [N_W-1:0]   q_r, q_nxt;

  logic [N_W-1:0] rem_r [DIV_STEPS];
  logic [Q_W-1:0] quo_r [DIV_STEPS];
  logic [Q_W-1:0] xs_r  [DIV_STEPS];
  logic [N_W-1:0] qs_r  [DIV_STEPS];

  always_comb begin
    cmp   = FREQ_ONE - freq;
    prod  = {{P_W{1'b0}}, freq} * {{P_W{1'b0}}, cmp};
    x_nxt = prod[Q_W-1:0];
    q_nxt = count - N_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      q_r <= q_nxt;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [N_W-1:0] rem_in, qd_in, rem_nxt;
    logic [Q_W-1:0] x_in, quo_in, quo_nxt;
    logic [N_W:0]   trial, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign x_in   = x_r;
      assign qd_in  = q_r;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign x_in   = xs_r[k-1];
      assign qd_in  = qs_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, x_in[Q_W-1-k]};
      diff    = trial - {1'b0, qd_in};
      ge      = trial >= {1'b0, qd_in};
      rem_nxt = ge ? diff[N_W-1:0] : trial[N_W-1:0];
      quo_nxt = quo_in;
      quo_nxt[Q_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        xs_r[k]  <= x_in;
        qs_r[k]  <= qd_in;
      end
    end
  end

  assign term = quo_r[DIV_STEPS-1];

endmodule

@@ design/pbs_log2.sv @@
// Pipelined log2 of an integer: exponent plus 30 fraction bits by repeated squaring.
`timescale 1ns / 1ps
module pbs_log2 import pbs_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [X_W-1:0] x,
  output logic [L_W-1:0] lg
);

  logic [X_W-1:0] xz, x_r;
  logic [E_W-1:0] e_nxt, e_r, e2_r;
  logic [M_W-1:0] m_nxt, m_r;

  logic [M_W-1:0]    ms_r [LOG_FB];
  logic [LOG_FB-1:0] fs_r [LOG_FB];
  logic [E_W-1:0]    es_r [LOG_FB];

  always_comb begin
    xz    = (x == '0) ? X_W'(1) : x;
    e_nxt = '0;
    for (int i = 0; i < X_W; i++) begin
      if (xz[i]) e_nxt = E_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= xz;
      e_r <= e_nxt;
    end
  end

  // normalize to a Q1.30 mantissa, truncating
  always_comb begin
    if (e_r <= E_W'(LOG_FB)) begin
      m_nxt = M_W'(x_r << (E_W'(LOG_FB) - e_r));
    end else begin
      m_nxt = M_W'(x_r >> (e_r - E_W'(LOG_FB)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= m_nxt;
      e2_r <= e_r;
    end
  end

  for (genvar j = 0; j < LOG_FB; j++) begin : g_sq
    logic [M_W-1:0]    m_in, mo_nxt;
    logic [LOG_FB-1:0] f_in, f_nxt;
    logic [E_W-1:0]    e_in;
    logic [2*M_W-1:0]  sq;
    logic [M_W:0]      top;

    if (j == 0) begin : g_first
      assign m_in = m_r;
      assign f_in = '0;
      assign e_in = e2_r;
    end else begin : g_next
      assign m_in = ms_r[j-1];
      assign f_in = fs_r[j-1];
      assign e_in = es_r[j-1];
    end

    always_comb begin
      sq    = {{M_W{1'b0}}, m_in} * {{M_W{1'b0}}, m_in};
      top   = sq[2*M_W-1:LOG_FB];
      f_nxt = f_in;
      if (top[M_W]) begin
        mo_nxt = top[M_W:1];
        f_nxt[LOG_FB-1-j] = 1'b1;
      end else begin
        mo_nxt = top[M_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ms_r[j] <= mo_nxt;
        fs_r[j] <= f_nxt;
        es_r[j] <= e_in;
      end
    end
  end

  assign lg = {es_r[LOG_FB-1], fs_r[LOG_FB-1]};

endmodule

@@ design/pbs_lane.sv @@
// One population pair: bias-corrected Fst turned into T = -ln(1-Fst).
`timescale 1ns / 1ps
module pbs_lane import pbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [P_W-1:0]       pi,
  input  logic [P_W-1:0]       pj,
  input  logic [N_W-1:0]       ni,
  input  logic [Q_W-1:0]       fi,
  input  logic [Q_W-1:0]       fj,
  output logic [FRAC_BITS+5:0] t_out
);

  localparam int TW = FRAC_BITS + 6;

  logic [P_W-1:0]   d, ci, cj;
  logic [2*P_W-1:0] d2w, p1w, p2w;
  logic             mono;

  logic [X_W-1:0] d2_r [DIV_LAT];
  logic [X_W-1:0] p1_r [DIV_LAT];
  logic [X_W-1:0] p2_r [DIV_LAT];
  logic           mo_r [DIV_LAT];
  logic [N_W-1:0] n_r  [DIV_LAT];

  logic [NUM_W-1:0] num_nxt, num_r;
  logic [X_W-1:0]   den_nxt, den_r;
  logic [N_W-1:0]   nn_r;
  logic             zn_nxt, zn_r;

  logic [X_W-1:0] nump, a_nxt, b_nxt, a_r, b_r;
  logic           one;
  logic           zm_r;
  logic           zl_r [LOG_LAT];

  logic [L_W-1:0]  la, lb, diff_nxt, diff_r;
  logic            zd_nxt, zd_r, zp_r;
  logic [PP_W-1:0] ph_r, pl_r;
  logic [63:0]     sum;
  logic [TW-1:0]   t_nxt, t_r;

  // front stage: square of difference and denominator products
  always_comb begin
    d    = (pi > pj) ? (pi - pj) : (pj - pi);
    ci   = FREQ_ONE - pi;
    cj   = FREQ_ONE - pj;
    d2w  = {{P_W{1'b0}}, d} * {{P_W{1'b0}}, d};
    p1w  = {{P_W{1'b0}}, pi} * {{P_W{1'b0}}, cj};
    p2w  = {{P_W{1'b0}}, pj} * {{P_W{1'b0}}, ci};
    mono = ((pi == '0) && (pj == '0)) || ((pi == FREQ_ONE) && (pj == FREQ_ONE));
  end

  // hold these until the per-population terms leave the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0] <= d2w[X_W-1:0];
      p1_r[0] <= p1w[X_W-1:0];
      p2_r[0] <= p2w[X_W-1:0];
      mo_r[0] <= mono;
      n_r[0]  <= ni;
      for (int k = 1; k < DIV_LAT; k++) begin
        d2_r[k] <= d2_r[k-1];
        p1_r[k] <= p1_r[k-1];
        p2_r[k] <= p2_r[k-1];
        mo_r[k] <= mo_r[k-1];
        n_r[k]  <= n_r[k-1];
      end
    end
  end

  always_comb begin
    num_nxt = NUM_W'(d2_r[DIV_LAT-1]) - NUM_W'(fi) - NUM_W'(fj);
    den_nxt = p1_r[DIV_LAT-1] + p2_r[DIV_LAT-1];
    zn_nxt  = mo_r[DIV_LAT-1] || num_nxt[NUM_W-1] || (num_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      nn_r  <= n_r[DIV_LAT-1];
      zn_r  <= zn_nxt;
    end
  end

  // Fst of one becomes 1-1/n, so the log pair is (n, 1)
  always_comb begin
    nump  = num_r[X_W-1:0];
    one   = nump >= den_r;
    a_nxt = one ? X_W'(nn_r) : den_r;
    b_nxt = one ? X_W'(1) : (den_r - nump);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      zm_r <= zn_r;
    end
  end

  pbs_log2 u_log_a (.clk(clk), .en(en), .x(a_r), .lg(la));
  pbs_log2 u_log_b (.clk(clk), .en(en), .x(b_r), .lg(lb));

  always_ff @(posedge clk) begin
    if (en) begin
      zl_r[0] <= zm_r;
      for (int k = 1; k < LOG_LAT; k++) begin
        zl_r[k] <= zl_r[k-1];
      end
    end
  end

  always_comb begin
    diff_nxt = la - lb;
    zd_nxt   = zl_r[LOG_LAT-1] || (la <= lb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      zd_r   <= zd_nxt;
      ph_r   <= {{LN2_W{1'b0}}, diff_r[L_W-1:SPLIT]} * {{SPLIT{1'b0}}, LN2_Q28};
      pl_r   <= {{LN2_W{1'b0}}, diff_r[SPLIT-1:0]} * {{SPLIT{1'b0}}, LN2_Q28};
      zp_r   <= zd_r;
    end
  end

  // combine partial products, round half up to Q.FRAC_BITS
  always_comb begin
    sum   = {ph_r, {SPLIT{1'b0}}} + 64'(pl_r) + (64'd1 << (57 - FRAC_BITS));
    t_nxt = zp_r ? '0 : sum[63:58-FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

  assign t_out = t_r;

endmodule

@@ design/pbs_merge.sv @@
// Merge stage: halved branch sums, clamped at zero, scaled to Q4.16 and saturated.
`timescale 1ns / 1ps
module pbs_merge import pbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS+5:0] tab,
  input  logic [FRAC_BITS+5:0] tac,
  input  logic [FRAC_BITS+5:0] tbc,
  output logic [OUT_W-1:0]     branch_a,
  output logic [OUT_W-1:0]     branch_b,
  output logic [OUT_W-1:0]     branch_c
);

  localparam int TW = FRAC_BITS + 6;
  localparam int VW = TW + 1;
  localparam int SH = FRAC_BITS - 15;

  logic [TW-1:0]    s0 [3];
  logic [TW-1:0]    s1 [3];
  logic [TW-1:0]    sub [3];
  logic [VW-1:0]    v_r [3];
  logic [OUT_W-1:0] o_r [3];

  assign s0[0] = tab; assign s1[0] = tac; assign sub[0] = tbc;
  assign s0[1] = tab; assign s1[1] = tbc; assign sub[1] = tac;
  assign s0[2] = tac; assign s1[2] = tbc; assign sub[2] = tab;

  for (genvar b = 0; b < 3; b++) begin : g_br
    logic [VW-1:0]    s, tt, v_nxt;
    logic [OUT_W-1:0] o_nxt;

    always_comb begin
      s     = {1'b0, s0[b]} + {1'b0, s1[b]};
      tt    = {1'b0, sub[b]};
      v_nxt = (s > tt) ? (s - tt) : '0;
    end

    if (SH > 0) begin : g_down
      logic [VW:0] rnd, shv;
      always_comb begin
        rnd   = {1'b0, v_r[b]} + (VW+1)'(1 << (SH - 1));
        shv   = rnd >> SH;
        o_nxt = (shv > (VW+1)'(OUT_MAX)) ? OUT_MAX : shv[OUT_W-1:0];
      end
    end else if (SH == 0) begin : g_same
      always_comb begin
        o_nxt = (v_r[b] > VW'(OUT_MAX)) ? OUT_MAX : v_r[b][OUT_W-1:0];
      end
    end else begin : g_up
      localparam int K   = -SH;
      localparam int LIM = 1048575 >> K;
      always_comb begin
        o_nxt = (v_r[b] > VW'(LIM)) ? OUT_MAX : (OUT_W'(v_r[b]) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[b] <= v_nxt;
        o_r[b] <= o_nxt;
      end
    end
  end

  assign branch_a = o_r[0];
  assign branch_b = o_r[1];
  assign branch_c = o_r[2];

endmodule

@@ design/population_branch_statistic.sv @@
// Top level of the population branch statistic: clamp, dividers, pair lanes, merge, output buffer.
`timescale 1ns / 1ps
// Population branch statistic for one site per word. Each input word carries three
// allele frequencies (Q0.16, 65536 = 1.0, larger values treated as 1.0) and three
// sampled allele counts (values below 2 treated as 2). Three pair lanes (ab, ac, bc)
// compute a bias-corrected Hudson Fst and T = -ln(1-Fst) side by side; the merge
// stage returns the three branch statistics (Tab+Tac-Tbc)/2 etc. in unsigned Q4.16,
// clamped at zero and saturated at 1048575. One word is accepted per cycle while
// in_ready is high and one result word leaves per cycle while out_ready is high;
// the pipeline depth comes mainly from the 31-stage p(1-p)/(n-1) divider and the
// 30-stage squaring log2 in each lane. A two-word output buffer lets the pipe keep
// taking input while a result waits; input stalls only when both buffer words are
// full. FRAC_BITS sets the internal fraction width of T (8 to 24).
module population_branch_statistic import pbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [P_W-1:0]   in_freq_a,
  input  logic [P_W-1:0]   in_freq_b,
  input  logic [P_W-1:0]   in_freq_c,
  input  logic [N_W-1:0]   in_count_a,
  input  logic [N_W-1:0]   in_count_b,
  input  logic [N_W-1:0]   in_count_c,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_branch_a,
  output logic [OUT_W-1:0] out_branch_b,
  output logic [OUT_W-1:0] out_branch_c
);

  localparam int TW    = FRAC_BITS + 6;
  localparam int DEPTH = 1 + LANE_LAT + MERGE_LAT;

  logic adv, push, pop;

  // pipeline valid bits, index 0 is the input register stage
  logic [DEPTH-1:0] vld_r, vld_nxt;

  logic [P_W-1:0] pa_r, pb_r, pc_r;
  logic [N_W-1:0] na_r, nb_r, nc_r;

  logic [Q_W-1:0] fa, fb, fc;
  logic [TW-1:0]  tab, tac, tbc;
  logic [OUT_W-1:0] ba, bb, bc;

  // two-word output buffer: word 0 drives the port
  logic [1:0]       cnt_r, cnt_nxt;
  logic [OUT_W-1:0] o0a_r, o0b_r, o0c_r, o1a_r, o1b_r, o1c_r;
  logic [OUT_W-1:0] o0a_nxt, o0b_nxt, o0c_nxt, o1a_nxt, o1b_nxt, o1c_nxt;

  // advance the whole pipe while the buffer has a free word
  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;
  assign push     = adv && vld_r[DEPTH-1];
  assign pop      = out_valid && out_ready;

  assign vld_nxt = {vld_r[DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // clamp the raw fields into their legal ranges
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= (in_freq_a > FREQ_ONE) ? FREQ_ONE : in_freq_a;
      pb_r <= (in_freq_b > FREQ_ONE) ? FREQ_ONE : in_freq_b;
      pc_r <= (in_freq_c > FREQ_ONE) ? FREQ_ONE : in_freq_c;
      na_r <= (in_count_a < N_W'(2)) ? N_W'(2) : in_count_a;
      nb_r <= (in_count_b < N_W'(2)) ? N_W'(2) : in_count_b;
      nc_r <= (in_count_c < N_W'(2)) ? N_W'(2) : in_count_c;
    end
  end

  // per-population sampling correction terms, shared by the lanes
  pbs_div u_div_a (.clk(clk), .en(adv), .freq(pa_r), .count(na_r), .term(fa));
  pbs_div u_div_b (.clk(clk), .en(adv), .freq(pb_r), .count(nb_r), .term(fb));
  pbs_div u_div_c (.clk(clk), .en(adv), .freq(pc_r), .count(nc_r), .term(fc));

  // pair lanes; an Fst of one uses the first population's count
  pbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_ab (
    .clk(clk), .en(adv), .pi(pa_r), .pj(pb_r), .ni(na_r), .fi(fa), .fj(fb), .t_out(tab)
  );
  pbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_ac (
    .clk(clk), .en(adv), .pi(pa_r), .pj(pc_r), .ni(na_r), .fi(fa), .fj(fc), .t_out(tac)
  );
  pbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_bc (
    .clk(clk), .en(adv), .pi(pb_r), .pj(pc_r), .ni(nb_r), .fi(fb), .fj(fc), .t_out(tbc)
  );

  pbs_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .en(adv), .tab(tab), .tac(tac), .tbc(tbc),
    .branch_a(ba), .branch_b(bb), .branch_c(bc)
  );

  // output buffer bookkeeping
  always_comb begin
    cnt_nxt = cnt_r;
    o0a_nxt = o0a_r; o0b_nxt = o0b_r; o0c_nxt = o0c_r;
    o1a_nxt = o1a_r; o1b_nxt = o1b_r; o1c_nxt = o1c_r;
    unique case (cnt_r)
      2'd0: begin
        if (push) begin
          o0a_nxt = ba; o0b_nxt = bb; o0c_nxt = bc;
          cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          o0a_nxt = ba; o0b_nxt = bb; o0c_nxt = bc;
        end else if (push) begin
          o1a_nxt = ba; o1b_nxt = bb; o1c_nxt = bc;
          cnt_nxt = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          o0a_nxt = o1a_r; o0b_nxt = o1b_r; o0c_nxt = o1c_r;
          cnt_nxt = 2'd1;
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o0a_r <= o0a_nxt; o0b_r <= o0b_nxt; o0c_r <= o0c_nxt;
    o1a_r <= o1a_nxt; o1b_r <= o1b_nxt; o1c_r <= o1c_nxt;
  end

  assign out_valid    = (cnt_r != 2'd0);
  assign out_branch_a = o0a_r;
  assign out_branch_b = o0b_r;
  assign out_branch_c = o0c_r;

endmodule

@@ sim/population_branch_statistic_checker.sv @@
// Checker for the population branch statistic: predicts each result word and compares it.
`timescale 1ns / 1ps
module population_branch_statistic_checker import pbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [P_W-1:0]   in_freq_a,
  input  logic [P_W-1:0]   in_freq_b,
  input  logic [P_W-1:0]   in_freq_c,
  input  logic [N_W-1:0]   in_count_a,
  input  logic [N_W-1:0]   in_count_b,
  input  logic [N_W-1:0]   in_count_c,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [OUT_W-1:0] out_branch_a,
  input  logic [OUT_W-1:0] out_branch_b,
  input  logic [OUT_W-1:0] out_branch_c,
  output int               fail_count,
  output int               pending_count,
  output int               checked_count
);

  typedef struct packed {
    logic [OUT_W-1:0] branch_a;
    logic [OUT_W-1:0] branch_b;
    logic [OUT_W-1:0] branch_c;
  } branch_word_t;

  branch_word_t branch_queue[$];

  function automatic longint unsigned log2_fixed(longint unsigned x);
    int                   e;
    longint unsigned      m;
    longint unsigned      frac;
    e    = 0;
    frac = 0;
    if (x == 0) x = 1;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e <= LOG_FB) m = x << (LOG_FB - e);
    else m = x >> (e - LOG_FB);
    for (int k = LOG_FB - 1; k >= 0; k--) begin
      m = (m * m) >> LOG_FB;
      if (m >= (64'd2 << LOG_FB)) begin
        m = m >> 1;
        frac = frac | (64'd1 << k);
      end
    end
    return (longint'(e) << LOG_FB) | frac;
  endfunction

  // Divergence T = -ln(1-Fst) of one population pair, Q.FRAC_BITS.
  function automatic longint unsigned pair_divergence(longint unsigned pi, longint unsigned pj,
                                                      longint unsigned ni, longint unsigned nj,
                                                      longint unsigned nfix);
    longint unsigned d, fi, fj, den, a, b, la, lb, prod;
    longint          num;
    if ((pi == 0 && pj == 0) || (pi == FREQ_ONE && pj == FREQ_ONE)) return 0;
    d   = pi > pj ? pi - pj : pj - pi;
    fi  = (pi * (FREQ_ONE - pi)) / (ni - 1);
    fj  = (pj * (FREQ_ONE - pj)) / (nj - 1);
    num = longint'(d * d) - longint'(fi) - longint'(fj);
    if (num <= 0) return 0;
    den = pi * (FREQ_ONE - pj) + pj * (FREQ_ONE - pi);
    if (unsigned'(num) >= den) begin
      a = nfix;
      b = 1;
    end else begin
      a = den;
      b = den - unsigned'(num);
    end
    la = log2_fixed(a);
    lb = log2_fixed(b);
    if (la <= lb) return 0;
    prod = (la - lb) * 64'(LN2_Q28);
    return (prod + (64'd1 << (57 - FRAC_BITS))) >> (58 - FRAC_BITS);
  endfunction

  function automatic logic [OUT_W-1:0] half_branch(longint unsigned s, longint unsigned t);
    int              sh;
    longint unsigned v;
    sh = FRAC_BITS + 1 - 16;
    if (s <= t) return '0;
    v = s - t;
    if (sh > 0) v = (v + (64'd1 << (sh - 1))) >> sh;
    else if (sh < 0) begin
      if (v > (64'(OUT_MAX) >> (-sh))) return OUT_MAX;
      v = v << (-sh);
    end
    return v > OUT_MAX ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  function automatic branch_word_t predict_branches(logic [P_W-1:0] fa, logic [P_W-1:0] fb,
                                                    logic [P_W-1:0] fc, logic [N_W-1:0] na,
                                                    logic [N_W-1:0] nb, logic [N_W-1:0] nc);
    longint unsigned p[3], n[3], tab, tac, tbc;
    branch_word_t    w;
    p[0] = fa; p[1] = fb; p[2] = fc;
    n[0] = na; n[1] = nb; n[2] = nc;
    for (int i = 0; i < 3; i++) begin
      if (p[i] > FREQ_ONE) p[i] = FREQ_ONE;
      if (n[i] < 2) n[i] = 2;
    end
    tab = pair_divergence(p[0], p[1], n[0], n[1], n[0]);
    tac = pair_divergence(p[0], p[2], n[0], n[2], n[0]);
    tbc = pair_divergence(p[1], p[2], n[1], n[2], n[1]);
    w.branch_a = half_branch(tab + tac, tbc);
    w.branch_b = half_branch(tab + tbc, tac);
    w.branch_c = half_branch(tac + tbc, tab);
    return w;
  endfunction

  assign pending_count = branch_queue.size();

  initial begin
    fail_count    = 0;
    checked_count = 0;
  end

  always @(posedge clk) begin
    branch_word_t exp_w;
    if (rst_n) begin
      if (in_valid && in_ready)
        branch_queue.insert(branch_queue.size(),
                            predict_branches(in_freq_a, in_freq_b, in_freq_c,
                                             in_count_a, in_count_b, in_count_c));
      if (out_valid && out_ready) begin
        if (branch_queue.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count++;
        end else begin
          exp_w = branch_queue.pop_front();
          checked_count++;
          if (out_branch_a !== exp_w.branch_a) begin
            $error("branch_a expected %0d actual %0d", exp_w.branch_a, out_branch_a);
            fail_count++;
          end
          if (out_branch_b !== exp_w.branch_b) begin
            $error("branch_b expected %0d actual %0d", exp_w.branch_b, out_branch_b);
            fail_count++;
          end
          if (out_branch_c !== exp_w.branch_c) begin
            $error("branch_c expected %0d actual %0d", exp_w.branch_c, out_branch_c);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ sim/population_branch_statistic_tb.sv @@
// Testbench top for the population branch statistic: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module population_branch_statistic_tb;
  import pbs_pkg::*;

  localparam int  RANDOM_WORDS = 1150;
  localparam int  CYCLE_LIMIT  = 400000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [P_W-1:0]   in_freq_a = '0, in_freq_b = '0, in_freq_c = '0;
  logic [N_W-1:0]   in_count_a = '0, in_count_b = '0, in_count_c = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] out_branch_a, out_branch_b, out_branch_c;

  int fail_count, pending_count, checked_count;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;
  int sent_count = 0;

  always #1 clk = ~clk;

  population_branch_statistic u_dut (.*);

  population_branch_statistic_checker u_checker (.*);

  // Receiver: drop ready at random at the configured stall rate.
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);

  // Guard against a hung pipe.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Hold one word on the channel until it is taken, then idle cycle by cycle at random.
  task automatic send_word(logic [P_W-1:0] fa, logic [P_W-1:0] fb, logic [P_W-1:0] fc,
                           logic [N_W-1:0] na, logic [N_W-1:0] nb, logic [N_W-1:0] nc);
    logic taken;
    in_freq_a  <= fa;
    in_freq_b  <= fb;
    in_freq_c  <= fc;
    in_count_a <= na;
    in_count_b <= nb;
    in_count_c <= nc;
    in_valid   <= 1'b1;
    do begin
      @(posedge clk);
      taken = in_ready;
    end while (!taken);
    sent_count++;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Frequencies lean toward the fixed points 0 and 1.0, and sometimes exceed 1.0, so the special cases recur.
  function automatic logic [P_W-1:0] pick_freq();
    unique case ($urandom_range(9))
      0:       return '0;
      1:       return FREQ_ONE;
      2:       return P_W'($urandom_range(131071, 65537));
      3:       return P_W'($urandom_range(64));
      4:       return P_W'($urandom_range(65536, 65472));
      default: return P_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [N_W-1:0] pick_count();
    unique case ($urandom_range(7))
      0:       return N_W'($urandom_range(2));
      1:       return 16'hFFFF;
      2, 3:    return N_W'($urandom_range(60, 2));
      default: return N_W'($urandom);
    endcase
  endfunction

  task automatic random_phase(int words, int idle_pct, int stall_pct);
    logic [P_W-1:0] fa;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (words) begin
      fa = pick_freq();
      // Sometimes repeat a frequency so pairs come out monomorphic or near equal.
      if ($urandom_range(5) == 0)
        send_word(fa, fa, pick_freq(), pick_count(), pick_count(), pick_count());
      else
        send_word(fa, pick_freq(), pick_freq(), pick_count(), pick_count(), pick_count());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: monomorphic pairs at 0 and at 1.0.
    send_word(17'd0, 17'd0, 17'd0, 16'd10, 16'd10, 16'd10);
    send_word(FREQ_ONE, FREQ_ONE, FREQ_ONE, 16'd10, 16'd10, 16'd10);
    // Fst of one: frequencies at 0 and 1.0, counts at the extremes and in between.
    send_word(17'd0, FREQ_ONE, FREQ_ONE, 16'hFFFF, 16'd2, 16'd2);
    send_word(FREQ_ONE, 17'd0, 17'd0, 16'd2, 16'hFFFF, 16'hFFFF);
    send_word(17'd0, FREQ_ONE, 17'd0, 16'd1000, 16'd7, 16'd3);
    send_word(FREQ_ONE, FREQ_ONE, 17'd0, 16'd5, 16'd40000, 16'd9);
    // Frequencies above 1.0 and counts below two.
    send_word(17'h1FFFF, 17'd0, 17'h10001, 16'd0, 16'd1, 16'hFFFF);
    send_word(17'h1FFFF, 17'h1FFFF, 17'h0FFFF, 16'd1, 16'd0, 16'd0);
    // Non-positive numerators: close frequencies, tiny samples.
    send_word(17'd30000, 17'd30100, 17'd29900, 16'd2, 16'd2, 16'd2);
    send_word(17'd1, 17'd2, 17'd3, 16'd3, 16'd3, 16'd3);
    // Negative branch sums: one population far from two close ones and the reverse.
    send_word(17'd32768, 17'd1000, 17'd64000, 16'd500, 16'd500, 16'd500);
    send_word(17'd1000, 17'd1200, 17'd65000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(17'd65535, 17'd1, 17'd32768, 16'hFFFF, 16'hFFFF, 16'd2);
    send_word(17'h0AAAA, 17'h15555, 17'h05555, 16'hAAAA, 16'h5555, 16'h8000);

    // Random phases under each flow-control pattern.
    random_phase(290, 0, 0);
    // Let the pipe drain completely before carrying on.
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    random_phase(290, 46, 0);
    random_phase(290, 0, 46);
    random_phase(280, 16, 16);

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LANE_LAT + MERGE_LAT + 30) @(negedge clk);

    $display("Sent %0d site words, checked %0d branch results", sent_count, checked_count);
    $display("Covered fixed and monomorphic pairs, clamped inputs and random stalls");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/pbs_pkg.sv
design/pbs_div.sv
design/pbs_log2.sv
design/pbs_lane.sv
design/pbs_merge.sv
design/population_branch_statistic.sv
sim/population_branch_statistic_checker.sv
sim/population_branch_statistic_tb.sv
